[rtl/tpr_pkg.sv]
// Shared types, constants and the square-root step of the torus residual unit.
// No dependencies; imported by torus_point_residual_unit.
package tpr_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // Configuration register indexes
  typedef enum logic [7:0] {
    CFG_AXIS_X   = 8'd0,
    CFG_AXIS_Y   = 8'd1,
    CFG_AXIS_Z   = 8'd2,
    CFG_CENTRE_X = 8'd3,
    CFG_CENTRE_Y = 8'd4,
    CFG_CENTRE_Z = 8'd5,
    CFG_MAJOR    = 8'd6,
    CFG_MINOR    = 8'd7
  } cfg_idx_e;

  // Digit-by-digit square root state: operand bits still to consume, partial
  // root and partial remainder
  typedef struct packed {
    logic [127:0] x;
    logic [63:0]  root;
    logic [64:0]  rem;
  } sq_state_t;

  // Item side data carried along the pipeline
  typedef struct packed {
    logic        last;
    logic        degen;
    logic [32:0] height;
  } side_t;

  // Result transaction
  typedef struct packed {
    logic        last;
    logic        degen;
    logic [31:0] residual;
  } res_t;

  // One root bit: bring down two operand bits, try (root << 2) | 1
  function automatic sq_state_t sqrt_step(input sq_state_t s);
    logic [66:0] rem_s;
    logic [66:0] trial;
    sq_state_t   r;
    rem_s = {s.rem, s.x[127:126]};
    trial = {1'b0, s.root, 2'b01};
    r.x = {s.x[125:0], 2'b00};
    if (rem_s >= trial) begin
      r.rem  = 65'(rem_s - trial);
      r.root = {s.root[62:0], 1'b1};
    end else begin
      r.rem  = 65'(rem_s);
      r.root = {s.root[62:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[rtl/torus_point_residual_unit.sv]
// Torus residual unit: signed distance of a stream of points to a torus.
// Depends on tpr_pkg (types, register indexes, square-root step).
// One point per cycle while the axis normalizer is finished and the skid stage is empty.
// The two pipelined square roots have 64 and 35 stages.
// After reset and after every axis register write, a serial normalizer (prescale,
// square root, three restoring divisions) runs with s_tready low; configuration
// writes are always taken.
// rst is synchronous and clears valid bits, the normalizer state and the registers, but axis z resets to 1.0.
module torus_point_residual_unit
  import tpr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // point_x[31:0], point_y[63:32], point_z[95:64]
  input  logic         s_tlast,   // last_point
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // residual[31:0]
  output logic         m_tuser,   // degenerate
  output logic         m_tlast,   // last_residual
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam logic signed [36:0] RES_MAX = 37'sd2147483647;
  localparam logic signed [36:0] RES_MIN = -37'sd2147483648;
  localparam int SQA_STAGES = 64;
  localparam int SQB_STAGES = 35;

  // ---------------------------------------------------------------- config
  logic signed [COORD_BITS-1:0] axis [3];
  logic signed [COORD_BITS-1:0] centre [3];
  logic signed [COORD_BITS-1:0] major_radius;
  logic signed [COORD_BITS-1:0] minor_radius;
  logic axis_wr;
  logic axis_zero;

  assign cfg_ready = 1'b1;
  assign axis_wr = cfg_valid && (cfg_index == CFG_AXIS_X || cfg_index == CFG_AXIS_Y ||
                                 cfg_index == CFG_AXIS_Z);
  assign axis_zero = (axis[0] == '0) && (axis[1] == '0) && (axis[2] == '0);

  // Write registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      axis[0] <= '0;
      axis[1] <= '0;
      axis[2] <= COORD_BITS'(1 << FRAC_BITS);
      centre[0] <= '0;
      centre[1] <= '0;
      centre[2] <= '0;
      major_radius <= '0;
      minor_radius <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_AXIS_X:   axis[0] <= cfg_data;
        CFG_AXIS_Y:   axis[1] <= cfg_data;
        CFG_AXIS_Z:   axis[2] <= cfg_data;
        CFG_CENTRE_X: centre[0] <= cfg_data;
        CFG_CENTRE_Y: centre[1] <= cfg_data;
        CFG_CENTRE_Z: centre[2] <= cfg_data;
        CFG_MAJOR:    major_radius <= cfg_data;
        CFG_MINOR:    minor_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- axis normalizer
  typedef enum logic [2:0] {U_LOAD, U_NORM, U_SQ, U_SQRT, U_DIV, U_DONE} ustate_t;

  ustate_t             ustate;
  logic [31:0]         m [3];
  logic                sgn [3];
  logic [63:0]         sum;
  sq_state_t           sqs;
  logic [31:0]         n;
  logic [5:0]          cnt;
  logic [1:0]          idx;
  logic [31:0]         drem;
  logic [61:0]         dnum;
  logic [31:0]         dq;
  logic signed [31:0]  au [3];

  logic [31:0] m_sel;
  logic [31:0] m_nxt;
  logic        sgn_sel;
  logic [31:0] mx;
  logic [63:0] sum_next;
  sq_state_t   sqs_next;
  logic [32:0] drem_s;
  logic        qbit;
  logic [31:0] dq_next;
  logic [32:0] drem_sub;

  always_comb begin
    case (idx)
      2'd0: begin
        m_sel = m[0];
        m_nxt = m[1];
        sgn_sel = sgn[0];
      end
      2'd1: begin
        m_sel = m[1];
        m_nxt = m[2];
        sgn_sel = sgn[1];
      end
      default: begin
        m_sel = m[2];
        m_nxt = m[2];
        sgn_sel = sgn[2];
      end
    endcase
    mx = (m[0] > m[1]) ? m[0] : m[1];
    if (m[2] > mx) mx = m[2];
    sum_next = sum + m_sel * m_sel;
    sqs_next = sqrt_step(sqs);
    drem_s = {drem, dnum[61]};
    qbit = (drem_s >= {1'b0, n});
    drem_sub = drem_s - {1'b0, n};
    dq_next = {dq[30:0], qbit};
  end

  // Prescale, square root of the sum of squares, then one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst || axis_wr) begin
      ustate <= U_LOAD;
    end else begin
      case (ustate)
        U_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            m[i] <= axis[i][31] ? 32'(-axis[i]) : 32'(axis[i]);
            sgn[i] <= axis[i][31];
          end
          ustate <= axis_zero ? U_DONE : U_NORM;
        end
        U_NORM: begin
          if (mx[31:30] == 2'b00) begin
            for (int i = 0; i < 3; i++) m[i] <= {m[i][30:0], 1'b0};
          end else begin
            sum <= '0;
            idx <= 2'd0;
            ustate <= U_SQ;
          end
        end
        U_SQ: begin
          sum <= sum_next;
          if (idx == 2'd2) begin
            sqs.x <= {sum_next, 64'd0};
            sqs.root <= '0;
            sqs.rem <= '0;
            cnt <= '0;
            ustate <= U_SQRT;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        U_SQRT: begin
          sqs <= sqs_next;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            n <= sqs_next.root[31:0];
            idx <= 2'd0;
            cnt <= '0;
            drem <= '0;
            dnum <= {m[0], 30'd0};
            ustate <= U_DIV;
          end
        end
        U_DIV: begin
          drem <= qbit ? drem_sub[31:0] : drem_s[31:0];
          dnum <= {dnum[60:0], 1'b0};
          dq <= dq_next;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd61) begin
            case (idx)
              2'd0: au[0] <= sgn_sel ? -dq_next : dq_next;
              2'd1: au[1] <= sgn_sel ? -dq_next : dq_next;
              default: au[2] <= sgn_sel ? -dq_next : dq_next;
            endcase
            cnt <= '0;
            drem <= '0;
            dnum <= {m_nxt, 30'd0};
            idx <= idx + 2'd1;
            if (idx == 2'd2) ustate <= U_DONE;
          end
        end
        U_DONE: ;
        default: ustate <= U_LOAD;
      endcase
    end
  end

  // ------------------------------------------------------------- pipeline
  logic en;
  logic skid_valid;
  logic out_valid;
  res_t out_reg;
  res_t skid_reg;

  assign en = !skid_valid;
  assign s_tready = en && (ustate == U_DONE);

  logic signed [31:0] pt [3];
  assign pt[0] = s_tdata[31:0];
  assign pt[1] = s_tdata[63:32];
  assign pt[2] = s_tdata[95:64];

  logic               val1, val2, val3, val4, val5, val6, val7;
  logic               last1, last2, last3, last4;
  logic               deg2, deg3, deg4;
  logic signed [32:0] v1 [3];
  logic signed [64:0] p2 [9];
  logic signed [65:0] cr3 [3];
  logic signed [66:0] dot3;
  logic [62:0]        crm4 [3];
  logic [63:0]        dotm4;
  logic [61:0]        pp_hh [3];
  logic [62:0]        pp_hl [3];
  logic [63:0]        pp_ll [3];
  side_t              side5, side6, side7;
  logic [127:0]       sq6 [3];
  logic [127:0]       s7;

  sq_state_t          sqa [SQA_STAGES];
  side_t              sida [SQA_STAGES];
  logic               vala [SQA_STAGES];

  logic               valr1, valr2, valr3, valr4, valr5;
  side_t              sidr1, sidr2, sidr3, sidr4, sidr5;
  logic [34:0]        ring1;
  logic signed [36:0] diff2;
  logic [33:0]        dm3;
  logic [67:0]        dsq4;
  logic [65:0]        hsq4;
  logic [69:0]        tot5;

  sq_state_t          sqb [SQB_STAGES];
  side_t              sidb [SQB_STAGES];
  logic               valb [SQB_STAGES];

  logic               vald1, vald2;
  side_t              sidd1;
  logic signed [36:0] resd1;
  res_t               resd2;

  sq_state_t          sqa_in;
  sq_state_t          sqb_in;

  assign sqa_in = '{x: s7, root: '0, rem: '0};
  assign sqb_in = '{x: {tot5, 58'd0}, root: '0, rem: '0};

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      {val1, val2, val3, val4, val5, val6, val7} <= '0;
      {valr1, valr2, valr3, valr4, valr5, vald1, vald2} <= '0;
      for (int k = 0; k < SQA_STAGES; k++) vala[k] <= 1'b0;
      for (int k = 0; k < SQB_STAGES; k++) valb[k] <= 1'b0;
    end else if (en) begin
      val1 <= s_tvalid && s_tready;
      val2 <= val1;
      val3 <= val2;
      val4 <= val3;
      val5 <= val4;
      val6 <= val5;
      val7 <= val6;
      vala[0] <= val7;
      for (int k = 1; k < SQA_STAGES; k++) vala[k] <= vala[k-1];
      valr1 <= vala[SQA_STAGES-1];
      valr2 <= valr1;
      valr3 <= valr2;
      valr4 <= valr3;
      valr5 <= valr4;
      valb[0] <= valr5;
      for (int k = 1; k < SQB_STAGES; k++) valb[k] <= valb[k-1];
      vald1 <= valb[SQB_STAGES-1];
      vald2 <= vald1;
    end
  end

  // Payload; the whole pipeline holds while the skid stage is full
  always_ff @(posedge clk) begin
    if (en) begin
      // offset from centre
      for (int i = 0; i < 3; i++) v1[i] <= pt[i] - centre[i];
      last1 <= s_tlast;

      // cross and dot partial products
      p2[0] <= au[1] * v1[2];
      p2[1] <= au[2] * v1[1];
      p2[2] <= au[2] * v1[0];
      p2[3] <= au[0] * v1[2];
      p2[4] <= au[0] * v1[1];
      p2[5] <= au[1] * v1[0];
      for (int i = 0; i < 3; i++) p2[6+i] <= au[i] * v1[i];
      last2 <= last1;
      deg2 <= axis_zero || ((v1[0] == '0) && (v1[1] == '0) && (v1[2] == '0));

      // combine into a x v and a . v
      for (int i = 0; i < 3; i++) cr3[i] <= p2[2*i] - p2[2*i+1];
      dot3 <= p2[6] + p2[7] + p2[8];
      last3 <= last2;
      deg3 <= deg2;

      // magnitudes
      for (int i = 0; i < 3; i++) crm4[i] <= cr3[i][65] ? 63'(-cr3[i]) : 63'(cr3[i]);
      dotm4 <= dot3[66] ? 64'(-dot3) : 64'(dot3);
      last4 <= last3;
      deg4 <= deg3;

      // split squares into 32-bit partial products; round the height
      for (int i = 0; i < 3; i++) begin
        pp_hh[i] <= crm4[i][62:32] * crm4[i][62:32];
        pp_hl[i] <= crm4[i][62:32] * crm4[i][31:0];
        pp_ll[i] <= crm4[i][31:0] * crm4[i][31:0];
      end
      side5.last <= last4;
      side5.degen <= deg4;
      side5.height <= 33'((65'(dotm4) + 65'(1 << 29)) >> 30);

      // assemble the squares
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= ({66'd0, pp_hh[i]} << 64) + ({65'd0, pp_hl[i]} << 33) + {64'd0, pp_ll[i]};
      end
      side6 <= side5;

      // sum of squared cross components
      s7 <= sq6[0] + sq6[1] + sq6[2];
      side7 <= side6;

      // ring distance root
      sqa[0] <= sqrt_step(sqa_in);
      sida[0] <= side7;
      for (int k = 1; k < SQA_STAGES; k++) begin
        sqa[k] <= sqrt_step(sqa[k-1]);
        sida[k] <= sida[k-1];
      end

      // round ring to the coordinate scale
      ring1 <= 35'((65'(sqa[SQA_STAGES-1].root) + 65'(1 << 29)) >> 30);
      sidr1 <= sida[SQA_STAGES-1];

      // R - ring
      diff2 <= 37'(major_radius) - $signed({2'b00, ring1});
      sidr2 <= sidr1;

      dm3 <= diff2[36] ? 34'(-diff2) : 34'(diff2);
      sidr3 <= sidr2;

      dsq4 <= dm3 * dm3;
      hsq4 <= sidr3.height * sidr3.height;
      sidr4 <= sidr3;

      tot5 <= {2'b00, dsq4} + {4'd0, hsq4};
      sidr5 <= sidr4;

      // distance root
      sqb[0] <= sqrt_step(sqb_in);
      sidb[0] <= sidr5;
      for (int k = 1; k < SQB_STAGES; k++) begin
        sqb[k] <= sqrt_step(sqb[k-1]);
        sidb[k] <= sidb[k-1];
      end

      // subtract tube radius
      resd1 <= $signed({2'b00, sqb[SQB_STAGES-1].root[34:0]}) - 37'(minor_radius);
      sidd1 <= sidb[SQB_STAGES-1];

      // saturate; degenerate items give zero
      resd2.last <= sidd1.last;
      resd2.degen <= sidd1.degen;
      if (sidd1.degen) resd2.residual <= '0;
      else if (resd1 > RES_MAX) resd2.residual <= 32'h7fff_ffff;
      else if (resd1 < RES_MIN) resd2.residual <= 32'h8000_0000;
      else resd2.residual <= resd1[31:0];
    end
  end

  // ------------------------------------------------- output register + skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_reg <= resd2;
        out_valid <= vald2;
      end
    end else if (en && vald2) begin
      skid_reg <= resd2;
      skid_valid <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = out_reg.residual;
  assign m_tuser = out_reg.degen;
  assign m_tlast = out_reg.last;

  // ------------------------------------------------------------- assertions
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a transaction while the output register is empty");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 32'd0))
    else $error("degenerate result with nonzero residual");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (ustate != U_DONE) |-> !s_tready)
    else $error("input accepted while the axis normalizer runs");

  a_skid_freeze: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_tready) |=> skid_valid && $stable(vald2))
    else $error("pipeline moved while the skid stage was full");

endmodule
